// File: hdl/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg
// Shared types, constants and symbol tables for the Roman numeral encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rne_pkg;

  localparam int VALUE_W  = 12;
  localparam int DIGITS   = 4;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int SYMBOL_W = 8;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

  // ASCII codes of the numeral symbols
  localparam logic [SYMBOL_W-1:0] CH_I    = 8'h49;
  localparam logic [SYMBOL_W-1:0] CH_V    = 8'h56;
  localparam logic [SYMBOL_W-1:0] CH_X    = 8'h58;
  localparam logic [SYMBOL_W-1:0] CH_L    = 8'h4C;
  localparam logic [SYMBOL_W-1:0] CH_C    = 8'h43;
  localparam logic [SYMBOL_W-1:0] CH_D    = 8'h44;
  localparam logic [SYMBOL_W-1:0] CH_M    = 8'h4D;
  localparam logic [SYMBOL_W-1:0] CH_NONE = 8'h00;

  // Digit positions, most significant first
  localparam logic [1:0] POS_THOUSANDS = 2'd0;
  localparam logic [1:0] POS_HUNDREDS  = 2'd1;
  localparam logic [1:0] POS_TENS      = 2'd2;
  localparam logic [1:0] POS_UNITS     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SK_ONE,
    SK_FIVE,
    SK_TEN
  } sym_kind_t;

  typedef struct packed {
    logic load;
    logic bad;
  } emit_cmd_t;

  // Number of characters a decimal digit expands to
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Which symbol of the digit's set goes out at step s
  function automatic sym_kind_t digit_kind(input logic [3:0] d, input logic [1:0] s);
    sym_kind_t k;
    priority if (d == 4'd9) begin
      k = (s == 2'd0) ? SK_ONE : SK_TEN;
    end else if (d == 4'd4) begin
      k = (s == 2'd0) ? SK_ONE : SK_FIVE;
    end else if (d >= 4'd5) begin
      k = (s == 2'd0) ? SK_FIVE : SK_ONE;
    end else begin
      k = SK_ONE;
    end
    return k;
  endfunction

  function automatic logic [SYMBOL_W-1:0] sym_lookup(input logic [1:0] pos,
                                                     input sym_kind_t k);
    logic [SYMBOL_W-1:0] ch;
    unique case (pos)
      POS_THOUSANDS: ch = CH_M;
      POS_HUNDREDS: begin
        unique case (k)
          SK_ONE:  ch = CH_C;
          SK_FIVE: ch = CH_D;
          default: ch = CH_M;
        endcase
      end
      POS_TENS: begin
        unique case (k)
          SK_ONE:  ch = CH_X;
          SK_FIVE: ch = CH_L;
          default: ch = CH_C;
        endcase
      end
      default: begin
        unique case (k)
          SK_ONE:  ch = CH_I;
          SK_FIVE: ch = CH_V;
          default: ch = CH_X;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: hdl/roman_numeral_encoder.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// An accepted value goes through the 12-step serial BCD conversion, then the
// emitter skips zero digits and sends one character per cycle while the output
// is not stalled; 0 or a value above 3999 skips the conversion and gives a lone
// error item. A new value is taken only once the emitter has loaded the last
// item of the previous one, as in_stall is high outside idle.
// Synchronous reset returns to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module roman_numeral_encoder
  import rne_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [VALUE_W-1:0]  value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SYMBOL_W-1:0]      symbol,
  output logic                     last,
  output logic                     bad_value
);

  state_t          state, state_next;
  emit_cmd_t       cmd;
  logic            bcd_start;
  logic            bcd_done;
  logic            emit_done;
  logic [BCD_W-1:0] digits;
  logic            accept;
  logic            out_of_range;

  rne_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .bin_in (value),
    .done   (bcd_done),
    .digits (digits)
  );

  rne_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .digits    (digits),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .symbol    (symbol),
    .last      (last),
    .bad_value (bad_value),
    .done      (emit_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = (state != ST_IDLE);
    accept       = in_valid && (state == ST_IDLE);
    out_of_range = (value == '0) || (value > MAX_VALUE);
    bcd_start    = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (out_of_range) begin
            cmd.load   = 1'b1;
            cmd.bad    = 1'b1;
            state_next = ST_EMIT;
          end else begin
            bcd_start  = 1'b1;
            state_next = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_done_in_emit: assert property (@(posedge clk) disable iff (rst)
    emit_done |-> (state == ST_EMIT))
    else $error("emitter finished outside the emit phase");

  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    bcd_done |-> (state == ST_CONV))
    else $error("conversion finished outside the convert phase");

endmodule

`default_nettype wire

// File: hdl/rne_bcd.sv
// ----------------------------------------------------------------------------
// rne_bcd
// Bit-serial binary to BCD converter (shift and add-3), one input bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_bcd
  import rne_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [VALUE_W-1:0] bin_in,
  output logic                    done,
  output logic [BCD_W-1:0]        digits
);

  localparam int CNT_W = $clog2(VALUE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= bin_in;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  assign digits = bcd;

endmodule

`default_nettype wire

// File: hdl/rne_emit.sv
// ----------------------------------------------------------------------------
// rne_emit
// Walks the BCD digits one at a time and sends one numeral character per cycle
// into the output register while it is not stalled, or a lone error item.
// ----------------------------------------------------------------------------
`default_nettype none

module rne_emit
  import rne_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire emit_cmd_t           cmd,
  input  wire logic [BCD_W-1:0]    digits,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic [SYMBOL_W-1:0]      symbol,
  output logic                     last,
  output logic                     bad_value,
  output logic                     done
);

  logic             busy;
  logic             err;
  logic [BCD_W-1:0] dig;
  logic [1:0]       pos;
  logic [1:0]       step;

  logic [3:0] cur;
  logic       rest_zero;
  logic [2:0] len;
  logic       fin_digit;
  logic       out_free;
  logic       load_err;
  logic       load_char;
  logic       skip;

  always_comb begin
    cur       = dig[BCD_W-1 -: 4];
    rest_zero = (dig[BCD_W-5:0] == '0);
    len       = digit_len(cur);
    fin_digit = ({1'b0, step} == len - 3'd1);
    out_free  = !out_valid || !out_stall;
    load_err  = busy && err && out_free;
    skip      = busy && !err && (cur == 4'd0);
    load_char = busy && !err && (cur != 4'd0) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        busy <= 1'b1;
      end else if (load_err || (load_char && fin_digit && rest_zero)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      if (load_err || load_char) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err  <= cmd.bad;
      dig  <= digits;
      pos  <= POS_THOUSANDS;
      step <= 2'd0;
    end else if (skip || (load_char && fin_digit)) begin
      // digit finished: advance to the next one
      dig  <= {dig[BCD_W-5:0], 4'd0};
      pos  <= pos + 2'd1;
      step <= 2'd0;
    end else if (load_char) begin
      step <= step + 2'd1;
    end

    if (load_err) begin
      symbol    <= CH_NONE;
      last      <= 1'b1;
      bad_value <= 1'b1;
    end else if (load_char) begin
      symbol    <= sym_lookup(pos, digit_kind(cur, step));
      last      <= fin_digit && rest_zero;
      bad_value <= 1'b0;
    end
  end

  a_err_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_value |-> last && (symbol == CH_NONE))
    else $error("error item must be a lone item with no symbol");

  a_good_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_value |-> (symbol != CH_NONE))
    else $error("numeral item carries no symbol");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy && !done)
    else $error("emitter did not start on load");

endmodule

`default_nettype wire
